[hdl/wmrbv_pkg.sv]
// ============================================================================
// wmrbv_pkg : shared types and constants for the multi-read byte voter
// Widths, vote constants, the queue entry passed from front to back and the
// request bundle for the confidence divider.
// ============================================================================
`default_nettype none

package wmrbv_pkg;

    // sizing
    localparam int MAX_REVISIONS = 8;
    localparam int SECTOR_BYTES  = 8192;
    localparam int REV_W         = $clog2(MAX_REVISIONS + 1);
    localparam int MASK_W        = 8;
    localparam int MASK_IDX_W    = $clog2(MASK_W);
    localparam int SLOT_N        = 8;
    localparam int SLOT_IDX_W    = $clog2(SLOT_N);
    localparam int USED_W        = $clog2(SLOT_N + 1);

    // field widths
    localparam int BYTE_W    = 8;
    localparam int CONF_W    = 8;
    localparam int ITEM_WT_W = 9;
    localparam int VOTE_W    = 12;
    localparam int POS_W     = 13;
    localparam int CNT_W     = 14;
    localparam int QUO_W     = 8;
    localparam int NUM_W     = VOTE_W + QUO_W;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GOOD_CRC_MASK = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_FUSION   = 1'd1;

    // vote constants
    localparam logic [ITEM_WT_W-1:0] CRC_BONUS   = 9'd100;
    localparam logic [QUO_W-1:0]     CONF_SCALE  = 8'd255;
    localparam logic [QUO_W-1:0]     ERROR_LIMIT = 8'd128;
    localparam logic [CNT_W-1:0]     CNT_MAX     = 14'h3FFF;
    localparam logic [CNT_W-1:0]     FIRST_NONE  = CNT_W'(SECTOR_BYTES);

    // front-to-back queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one classified revision beat
    typedef struct packed {
        logic [BYTE_W-1:0]     rbyte;
        logic [ITEM_WT_W-1:0]  weight;
        logic                  vote;     // adds a vote and a mask bit
        logic [MASK_IDX_W-1:0] rev_bit;  // mask bit of this revision
        logic                  is_ref;   // revision zero: weak reference
        logic                  last;
        logic                  fresh;
    } t_entry;

    // divider request
    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [VOTE_W-1:0] den;
    } t_div_req;

endpackage

`default_nettype wire

[hdl/wmrbv_front.sv]
// ============================================================================
// wmrbv_front : input side and configuration registers
// Tracks the revision index, works out each beat's weight and vote flags and
// pushes the classified beat into the queue. Beats are dropped when fusion
// is skipped.
// ============================================================================
`default_nettype none

module wmrbv_front
    import wmrbv_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data,
    // input beat
    input  wire logic                 i_push,
    input  wire logic [BYTE_W-1:0]    i_read_byte,
    input  wire logic [CONF_W-1:0]    i_read_confidence,
    input  wire logic                 i_present,
    input  wire logic                 i_last_revision,
    input  wire logic                 i_new_sector,
    // queue side
    input  wire logic                 i_q_full,
    output logic                      o_q_push,
    output t_entry                    o_entry
);

    logic [MASK_W-1:0] r_crc_mask;
    logic              r_skip;
    logic [REV_W-1:0]  r_rev, n_rev;
    logic [REV_W-1:0]  rev_eff;
    logic              rev_ok;
    logic              accept;

    assign o_cfg_ready = 1'b1;
    assign accept      = i_push && !i_q_full;

    // classification of the incoming beat
    always_comb begin
        rev_eff = i_new_sector ? '0 : r_rev;
        rev_ok  = rev_eff < REV_W'(MAX_REVISIONS);

        o_entry.rbyte   = i_read_byte;
        o_entry.rev_bit = rev_eff[MASK_IDX_W-1:0];
        o_entry.vote    = i_present && rev_ok;
        o_entry.is_ref  = (rev_eff == '0);
        o_entry.last    = i_last_revision;
        o_entry.fresh   = i_new_sector;
        o_entry.weight  = ITEM_WT_W'(i_read_confidence)
                        + ((rev_ok && r_crc_mask[rev_eff[MASK_IDX_W-1:0]])
                           ? CRC_BONUS : '0);

        o_q_push = accept && !r_skip;

        // revision index saturates at the limit, a last beat restarts it
        n_rev = r_rev;
        if (o_q_push) begin
            if (i_last_revision) begin
                n_rev = '0;
            end else if (rev_ok) begin
                n_rev = rev_eff + REV_W'(1);
            end else begin
                n_rev = rev_eff;
            end
        end
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_mask <= '0;
            r_skip     <= 1'b0;
            r_rev      <= '0;
        end else begin
            r_rev <= n_rev;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_GOOD_CRC_MASK: r_crc_mask <= i_cfg_data;
                    CFG_SKIP_FUSION:   r_skip     <= i_cfg_data[0];
                    default:           r_skip     <= r_skip;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

[hdl/wmrbv_queue.sv]
// ============================================================================
// wmrbv_queue : short queue between front and back
// Four-entry register queue of classified beats.
// ============================================================================
`default_nettype none

module wmrbv_queue
    import wmrbv_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  t_entry      i_entry,
    output logic        o_full,
    input  wire logic   i_pop,
    output t_entry      o_entry,
    output logic        o_empty
);

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr, n_wr;
    logic [QPTR_W-1:0]   r_rd, n_rd;
    logic [QCNT_W-1:0]   r_cnt, n_cnt;
    logic                do_push, do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_entry = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointers
    always_comb begin
        n_wr  = do_push ? r_wr + QPTR_W'(1) : r_wr;
        n_rd  = do_pop  ? r_rd + QPTR_W'(1) : r_rd;
        n_cnt = r_cnt + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

[hdl/wmrbv_div.sv]
// ============================================================================
// wmrbv_div : serial divider for the fused confidence
// Restoring division, one quotient bit per cycle. Quotient is
// valid in the cycle done is high and holds until the next start.
// ============================================================================
`default_nettype none

module wmrbv_div
    import wmrbv_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  t_div_req          i_req,
    output logic              o_done,
    output logic [QUO_W-1:0]  o_quot
);

    localparam int STEP_W = $clog2(QUO_W);

    logic [NUM_W-1:0]  r_rem, n_rem;
    logic [NUM_W-1:0]  r_dsh, n_dsh;
    logic [QUO_W-1:0]  r_q, n_q;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic              ge;

    assign o_done = r_done;
    assign o_quot = r_q;

    // one restoring step per cycle
    always_comb begin
        ge     = (r_rem >= r_dsh);
        n_rem  = r_rem;
        n_dsh  = r_dsh;
        n_q    = r_q;
        n_step = r_step;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_rem  = i_req.num;
            n_dsh  = NUM_W'(i_req.den) << (QUO_W - 1);
            n_q    = '0;
            n_step = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem  = ge ? r_rem - r_dsh : r_rem;
            n_dsh  = r_dsh >> 1;
            n_q    = {r_q[QUO_W-2:0], ge};
            n_step = r_step + STEP_W'(1);
            if (r_step == STEP_W'(QUO_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dsh <= n_dsh;
        r_q   <= n_q;
    end

endmodule

`default_nettype wire

[hdl/wmrbv_back.sv]
// ============================================================================
// wmrbv_back : vote engine, position close and result register
// Takes one queued beat a cycle into the vote slots while no position is being
// closed; on the last beat of a position it runs the divider, updates the
// sector counters and loads the result register.
// ============================================================================
`default_nettype none

module wmrbv_back
    import wmrbv_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // queue side
    input  t_entry                 i_entry,
    input  wire logic              i_q_empty,
    output logic                   o_q_pop,
    // divider
    output t_div_req               o_div_req,
    input  wire logic              i_div_done,
    input  wire logic [QUO_W-1:0]  i_div_quot,
    // result side
    input  wire logic              i_pop,
    output logic                   o_empty,
    output logic [POS_W-1:0]       o_position,
    output logic [BYTE_W-1:0]      o_fused_byte,
    output logic [QUO_W-1:0]       o_fused_confidence,
    output logic                   o_weak_res,
    output logic                   o_error,
    output logic [MASK_W-1:0]      o_presence_mask,
    output logic [CNT_W-1:0]       o_first_error_position,
    output logic [CNT_W-1:0]       o_weak_count,
    output logic [CNT_W-1:0]       o_error_count,
    output logic [CNT_W-1:0]       o_valid_count
);

    localparam logic [1:0] S_RUN   = 2'd0;
    localparam logic [1:0] S_START = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

    logic [1:0]            r_state, n_state;

    // vote slots
    logic [BYTE_W-1:0]     r_slot_val [SLOT_N];
    logic [VOTE_W-1:0]     r_slot_wt  [SLOT_N];

    // position state
    logic [USED_W-1:0]     r_used, n_used;
    logic [BYTE_W-1:0]     r_best_val, n_best_val;
    logic [VOTE_W-1:0]     r_best_wt, n_best_wt;
    logic [VOTE_W-1:0]     r_total, n_total;
    logic [BYTE_W-1:0]     r_ref, n_ref;
    logic                  r_agree, n_agree;
    logic [MASK_W-1:0]     r_mask, n_mask;

    // sector state
    logic [POS_W-1:0]      r_pos, n_pos;
    logic [CNT_W-1:0]      r_ferr, n_ferr;
    logic [CNT_W-1:0]      r_weak_cnt, n_weak_cnt;
    logic [CNT_W-1:0]      r_err_cnt, n_err_cnt;
    logic [CNT_W-1:0]      r_val_cnt, n_val_cnt;

    logic                  r_out_valid, n_out_valid;

    // vote working signals
    logic [USED_W-1:0]     eff_used;
    logic                  hit, new_slot, do_add;
    logic [SLOT_IDX_W-1:0] hit_idx, wr_idx;
    logic [VOTE_W-1:0]     base, sum;
    logic                  slot_we;

    // close working signals
    logic [QUO_W-1:0]      conf;
    logic                  err, pos_weak, load;

    assign o_q_pop = (r_state == S_RUN) && !i_q_empty;
    assign o_empty = !r_out_valid;

    // slot search and accumulate
    always_comb begin
        eff_used = i_entry.fresh ? '0 : r_used;
        hit      = 1'b0;
        hit_idx  = '0;
        for (int k = SLOT_N - 1; k >= 0; k--) begin
            if (USED_W'(k) < eff_used && r_slot_val[k] == i_entry.rbyte) begin
                hit     = 1'b1;
                hit_idx = SLOT_IDX_W'(k);
            end
        end
        new_slot = !hit && (eff_used < USED_W'(SLOT_N));
        wr_idx   = hit ? hit_idx : eff_used[SLOT_IDX_W-1:0];
        base     = hit ? r_slot_wt[hit_idx] : '0;
        sum      = base + VOTE_W'(i_entry.weight);
        do_add   = i_entry.vote && (hit || new_slot);
        slot_we  = o_q_pop && do_add;
    end

    // position close values
    always_comb begin
        conf     = (r_total == '0) ? '0 : i_div_quot;
        err      = conf < ERROR_LIMIT;
        pos_weak = !r_agree;
        load     = (r_state == S_FIN) && (!r_out_valid || i_pop);
    end

    // divider request uses the settled position totals
    always_comb begin
        o_div_req.start = (r_state == S_START);
        o_div_req.num   = NUM_W'(r_best_wt) * NUM_W'(CONF_SCALE);
        o_div_req.den   = r_total;
    end

    // control and state update
    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_best_val  = r_best_val;
        n_best_wt   = r_best_wt;
        n_total     = r_total;
        n_ref       = r_ref;
        n_agree     = r_agree;
        n_mask      = r_mask;
        n_pos       = r_pos;
        n_ferr      = r_ferr;
        n_weak_cnt  = r_weak_cnt;
        n_err_cnt   = r_err_cnt;
        n_val_cnt   = r_val_cnt;
        n_out_valid = (r_out_valid && !i_pop) || load;

        case (r_state)
            S_RUN: begin
                if (o_q_pop) begin
                    // a new sector drops the partial position and the counts
                    if (i_entry.fresh) begin
                        n_used     = '0;
                        n_best_val = '0;
                        n_best_wt  = '0;
                        n_total    = '0;
                        n_ref      = '0;
                        n_agree    = 1'b1;
                        n_mask     = '0;
                        n_pos      = '0;
                        n_ferr     = FIRST_NONE;
                        n_weak_cnt = '0;
                        n_err_cnt  = '0;
                        n_val_cnt  = '0;
                    end
                    if (i_entry.is_ref) begin
                        n_ref = i_entry.rbyte;
                    end
                    if (i_entry.vote) begin
                        n_mask = n_mask | (MASK_W'(1) << i_entry.rev_bit);
                        if (!i_entry.is_ref && i_entry.rbyte != n_ref) begin
                            n_agree = 1'b0;
                        end
                    end
                    if (do_add) begin
                        if (new_slot) begin
                            n_used = eff_used + USED_W'(1);
                        end
                        n_total = n_total + VOTE_W'(i_entry.weight);
                        if (sum > n_best_wt) begin
                            n_best_wt  = sum;
                            n_best_val = i_entry.rbyte;
                        end
                    end
                    if (i_entry.last) begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (i_div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (load) begin
                    if (err && CNT_W'(r_pos) < r_ferr) begin
                        n_ferr = CNT_W'(r_pos);
                    end
                    if (pos_weak) begin
                        n_weak_cnt = sat_inc(r_weak_cnt);
                    end
                    if (err) begin
                        n_err_cnt = sat_inc(r_err_cnt);
                    end else begin
                        n_val_cnt = sat_inc(r_val_cnt);
                    end
                    n_pos      = r_pos + POS_W'(1);
                    n_used     = '0;
                    n_best_val = '0;
                    n_best_wt  = '0;
                    n_total    = '0;
                    n_ref      = '0;
                    n_agree    = 1'b1;
                    n_mask     = '0;
                    n_state    = S_RUN;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_used      <= '0;
            r_best_val  <= '0;
            r_best_wt   <= '0;
            r_total     <= '0;
            r_ref       <= '0;
            r_agree     <= 1'b1;
            r_mask      <= '0;
            r_pos       <= '0;
            r_ferr      <= FIRST_NONE;
            r_weak_cnt  <= '0;
            r_err_cnt   <= '0;
            r_val_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_best_val  <= n_best_val;
            r_best_wt   <= n_best_wt;
            r_total     <= n_total;
            r_ref       <= n_ref;
            r_agree     <= n_agree;
            r_mask      <= n_mask;
            r_pos       <= n_pos;
            r_ferr      <= n_ferr;
            r_weak_cnt  <= n_weak_cnt;
            r_err_cnt   <= n_err_cnt;
            r_val_cnt   <= n_val_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // slot write: only slots below the fill count are ever read
    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            r_slot_val[wr_idx] <= i_entry.rbyte;
            r_slot_wt[wr_idx]  <= sum;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (load) begin
            o_position             <= r_pos;
            o_fused_byte           <= r_best_val;
            o_fused_confidence     <= conf;
            o_weak_res             <= pos_weak;
            o_error                <= err;
            o_presence_mask        <= r_mask;
            o_first_error_position <= n_ferr;
            o_weak_count           <= n_weak_cnt;
            o_error_count          <= n_err_cnt;
            o_valid_count          <= n_val_cnt;
        end
    end

endmodule

`default_nettype wire

[hdl/weighted_multiread_byte_voter_top.sv]
// Flow: an accepted beat passes through the queue into the vote slots; the last
// beat of a position takes the back through its start, wait and finish states.
// Throughput: one revision beat per cycle while no position is being closed;
// each close runs the 8-step serial confidence divider.
// Reset: synchronous, active low; clears config, counters, queue and the result
// valid flag; first error position returns to the sector size.
// ============================================================================
// weighted_multiread_byte_voter_top : multi-read sector byte voter
// Front classifies revision beats, a short queue decouples it from the back
// that accumulates weighted votes and closes each byte position.
// ============================================================================
`default_nettype none

module weighted_multiread_byte_voter_top
    import wmrbv_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data,
    // input queue face
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [BYTE_W-1:0]    i_read_byte,
    input  wire logic [CONF_W-1:0]    i_read_confidence,
    input  wire logic                 i_present,
    input  wire logic                 i_last_revision,
    input  wire logic                 i_new_sector,
    // result queue face
    output logic                      empty,
    input  wire logic                 pop,
    output logic [POS_W-1:0]          o_position,
    output logic [BYTE_W-1:0]         o_fused_byte,
    output logic [QUO_W-1:0]          o_fused_confidence,
    output logic                      o_weak_res,
    output logic                      o_error,
    output logic [MASK_W-1:0]         o_presence_mask,
    output logic [CNT_W-1:0]          o_first_error_position,
    output logic [CNT_W-1:0]          o_weak_count,
    output logic [CNT_W-1:0]          o_error_count,
    output logic [CNT_W-1:0]          o_valid_count
);

    t_entry            fe_entry, q_entry;
    logic              q_push, q_pop, q_empty;
    t_div_req          div_req;
    logic              div_done;
    logic [QUO_W-1:0]  div_quot;

    wmrbv_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_push            (push),
        .i_read_byte       (i_read_byte),
        .i_read_confidence (i_read_confidence),
        .i_present         (i_present),
        .i_last_revision   (i_last_revision),
        .i_new_sector      (i_new_sector),
        .i_q_full          (full),
        .o_q_push          (q_push),
        .o_entry           (fe_entry)
    );

    wmrbv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (fe_entry),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_entry (q_entry),
        .o_empty (q_empty)
    );

    wmrbv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    wmrbv_back u_back (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_entry                (q_entry),
        .i_q_empty              (q_empty),
        .o_q_pop                (q_pop),
        .o_div_req              (div_req),
        .i_div_done             (div_done),
        .i_div_quot             (div_quot),
        .i_pop                  (pop),
        .o_empty                (empty),
        .o_position             (o_position),
        .o_fused_byte           (o_fused_byte),
        .o_fused_confidence     (o_fused_confidence),
        .o_weak_res             (o_weak_res),
        .o_error                (o_error),
        .o_presence_mask        (o_presence_mask),
        .o_first_error_position (o_first_error_position),
        .o_weak_count           (o_weak_count),
        .o_error_count          (o_error_count),
        .o_valid_count          (o_valid_count)
    );

    // back never takes a beat from an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    // error flag follows the confidence threshold
    a_error_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_error == (o_fused_confidence < ERROR_LIMIT)))
        else $error("error flag disagrees with confidence");

    // a position with no present revision has no confidence
    a_no_votes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_presence_mask == '0) |-> (o_fused_confidence == '0 && o_error))
        else $error("confidence without any vote");

    // the divider is only started while idle
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |=> !div_done)
        else $error("divider finished right after start");

endmodule

`default_nettype wire
